[hdl/jtp_pkg.sv]
// Shared constants, types and the sine boundary table for the joystick to polar drive block.
package jtp_pkg;

  // Field widths and fixed-point format.
  localparam int FRAC_BITS = 14;
  localparam int AXIS_W    = 16;
  localparam int SNAP_W    = 6;
  localparam int ANGLE_W   = 8;
  localparam int SPEED_W   = 16;
  localparam int MAG_W     = 16;

  // Sine table geometry: one entry per whole degree, unsigned Q0.46.
  localparam int TAB_N     = 91;
  localparam int IDX_W     = 7;
  localparam int SINE_W    = 46;
  localparam int SINE_LO_W = 23;
  localparam int SINE_HI_W = SINE_W - SINE_LO_W;
  localparam int PROD_W    = AXIS_W + SINE_LO_W;
  localparam int CMP_W     = 64;

  // Square root datapath.
  localparam int SUM_W     = 32;
  localparam int REM_W     = 20;

  // Pipeline layout: input stage, seven search steps of two stages each,
  // an angle stage and the output stage.
  localparam int SEARCH_STEPS = 7;
  localparam int NST          = 3 + 2 * SEARCH_STEPS;
  localparam int ST_SEARCH0   = 2;
  localparam int ST_SEARCH_END = ST_SEARCH0 + 2 * SEARCH_STEPS - 1;
  localparam int ST_SQUARE    = 2;
  localparam int ST_SUM       = 3;
  localparam int ST_ROOT0     = 4;
  localparam int ROOT_PER_ST  = 2;
  localparam int ROOT_STAGES  = (SUM_W / 2) / ROOT_PER_ST;
  localparam int ST_ANGLE     = NST - 1;

  // Angle codes and limits.
  localparam logic [SNAP_W-1:0]  SNAP_RESET   = 6'd3;
  localparam logic [IDX_W-1:0]   DEG_LAST     = 7'd89;
  localparam logic [IDX_W-1:0]   DEG_RIGHT    = 7'd90;
  localparam logic [ANGLE_W-1:0] ANGLE_FWD    = 8'd0;
  localparam logic [ANGLE_W-1:0] ANGLE_UP     = 8'd90;
  localparam logic [ANGLE_W-1:0] ANGLE_BACK   = 8'd180;
  localparam logic [MAG_W-1:0]   MAG_SAT      = 16'(1 << FRAC_BITS);

  // Fixed-point constants used to build the table.
  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;

  typedef logic [TAB_N-1:0][SINE_W-1:0] sine_tab_t;

  // Returns bits [sh+63:sh] of the full 128-bit product.
  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int unsigned sh);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p >> sh);
  endfunction

  // Sine of each whole degree: Taylor series for one degree in Q2.62,
  // then the Chebyshev recurrence, then rounding to Q0.46.
  function automatic sine_tab_t build_sine();
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] sterm;
    logic [63:0] ssum;
    logic [63:0] cterm;
    logic [63:0] csum;
    logic [63:0] s [0:TAB_N-1];
    sine_tab_t   tab;
    theta = PI_Q62 / 64'd180;
    t2    = mul_shift(theta, theta, 62);
    sterm = theta;
    ssum  = theta;
    cterm = ONE_Q62;
    csum  = ONE_Q62;
    for (int n = 1; n <= 6; n++) begin
      sterm = mul_shift(sterm, t2, 62) / 64'((2 * n) * (2 * n + 1));
      cterm = mul_shift(cterm, t2, 62) / 64'((2 * n - 1) * (2 * n));
      if ((n % 2) == 1) begin
        ssum = ssum - sterm;
        csum = csum - cterm;
      end else begin
        ssum = ssum + sterm;
        csum = csum + cterm;
      end
    end
    s[0] = '0;
    s[1] = ssum;
    for (int k = 1; k < TAB_N - 1; k++) begin
      s[k + 1] = mul_shift(csum, s[k], 61) - s[k - 1];
    end
    for (int k = 0; k < TAB_N; k++) begin
      tab[k] = SINE_W'((s[k] + (64'd1 << 15)) >> 16);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // Everything one pipeline stage carries.
  typedef struct packed {
    logic [AXIS_W-1:0]  ax;
    logic [AXIS_W-1:0]  ay;
    logic               x_zero;
    logic               y_zero;
    logic               x_pos;
    logic               y_neg;
    logic [IDX_W-1:0]   d;
    logic [IDX_W-1:0]   t;
    logic               t_ok;
    logic [PROD_W-1:0]  pa_hi;
    logic [PROD_W-1:0]  pa_lo;
    logic [PROD_W-1:0]  pb_hi;
    logic [PROD_W-1:0]  pb_lo;
    logic [SUM_W-1:0]   sq_x;
    logic [SUM_W-1:0]   sq_y;
    logic [SUM_W-1:0]   v;
    logic [REM_W-1:0]   rem;
    logic [MAG_W-1:0]   root;
    logic [ANGLE_W-1:0] angle;
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [SPEED_W-1:0] speed;
  } pipe_t;

endpackage

[hdl/jtp_if.sv]
// Valid/ready channel interfaces for joystick samples and drive commands.
interface jtp_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [jtp_pkg::AXIS_W-1:0] x_axis;
  logic signed [jtp_pkg::AXIS_W-1:0] y_axis;

  modport source (output valid, output x_axis, output y_axis, input ready);
  modport sink (input valid, input x_axis, input y_axis, output ready);
endinterface

interface jtp_out_if;
  logic                               valid;
  logic                               ready;
  logic        [jtp_pkg::ANGLE_W-1:0] angle_deg;
  logic signed [jtp_pkg::SPEED_W-1:0] speed;

  modport source (output valid, output angle_deg, output speed, input ready);
  modport sink (input valid, input angle_deg, input speed, output ready);
endinterface

[hdl/joystick_to_polar_drive.sv]
// Joystick to polar drive converter: top level with its seventeen-stage pipeline.
//
// Converts one joystick sample (x_axis, y_axis, signed Q1.14) into a drive direction
// folded to 0..180 whole degrees and a signed speed in Q1.14. The block takes one
// transaction per clock while the result port is not stalled; its pipeline depth is set
// by the seven-step binary search over the sine boundary table (a multiply stage
// and a compare stage per step) that runs beside a two-digit-per-stage square root.
// Every stage holds its own valid bit and moves on when the stage after it is free,
// so empty slots close up while the result port is stalled. The snap margin register
// resets to 3 degrees and should only be written while no transaction is in flight.
module joystick_to_polar_drive (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [jtp_pkg::SNAP_W-1:0] cfg_wr_data,
  jtp_in_if.sink                     sample,
  jtp_out_if.source                  result
);
  import jtp_pkg::*;

  logic [SNAP_W-1:0] snap;
  pipe_t             st [1:NST];
  pipe_t             nx [1:NST];
  logic [NST:1]      vld;
  logic [NST:1]      src_vld;
  logic [NST:1]      adv;

  // Snap margin register.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap <= SNAP_RESET;
    end else if (cfg_wr_en) begin
      snap <= cfg_wr_data;
    end
  end

  // Stage 1 takes the sample apart into magnitudes and sign flags.
  always_comb begin
    nx[1]        = '0;
    nx[1].ax     = sample.x_axis[AXIS_W-1] ? AXIS_W'(-sample.x_axis) : sample.x_axis;
    nx[1].ay     = sample.y_axis[AXIS_W-1] ? AXIS_W'(-sample.y_axis) : sample.y_axis;
    nx[1].x_zero = (sample.x_axis == '0);
    nx[1].y_zero = (sample.y_axis == '0);
    nx[1].x_pos  = !sample.x_axis[AXIS_W-1] && (sample.x_axis != '0);
    nx[1].y_neg  = sample.y_axis[AXIS_W-1];
    nx[1].d      = '0;
  end

  genvar i;
  generate
    for (i = 1; i <= NST; i++) begin : g_stage
      // Valid chain and per-stage advance.
      if (i == 1) begin : g_src_in
        assign src_vld[i] = sample.valid;
      end else begin : g_src_prev
        assign src_vld[i] = vld[i-1];
      end

      if (i == NST) begin : g_adv_out
        assign adv[i] = !vld[i] || result.ready;
      end else begin : g_adv_next
        assign adv[i] = !vld[i] || adv[i+1];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (adv[i]) begin
          vld[i] <= src_vld[i];
        end
      end

      always_ff @(posedge clk) begin
        if (adv[i]) begin
          st[i] <= nx[i];
        end
      end

      if (i >= 2) begin : g_work
        localparam int J      = (i - ST_SEARCH0) / 2;
        localparam int BIT_SH = (J < IDX_W) ? (IDX_W - 1 - J) : 0;
        localparam bit IS_MUL = (i >= ST_SEARCH0) && (i <= ST_SEARCH_END) &&
                                (((i - ST_SEARCH0) % 2) == 0);
        localparam bit IS_CMP = (i >= ST_SEARCH0) && (i <= ST_SEARCH_END) &&
                                (((i - ST_SEARCH0) % 2) == 1);
        localparam bit IS_ROOT = (i >= ST_ROOT0) && (i < ST_ROOT0 + ROOT_STAGES);

        always_comb begin
          logic [IDX_W-1:0]   t_w;
          logic [IDX_W-1:0]   idx_s;
          logic [IDX_W-1:0]   idx_c;
          logic [SINE_W-1:0]  s_ent;
          logic [SINE_W-1:0]  c_ent;
          logic [CMP_W-1:0]   lhs;
          logic [CMP_W-1:0]   rhs;
          logic [REM_W-1:0]   trial;
          logic [ANGLE_W:0]   a_raw;
          logic [ANGLE_W:0]   a_fin;
          logic               snapped;
          nx[i] = st[i-1];

          // Search step, first half: look up the boundary and form partial products.
          if (IS_MUL) begin
            t_w   = st[i-1].d | IDX_W'(1 << BIT_SH);
            idx_s = (t_w <= DEG_LAST) ? t_w : '0;
            idx_c = DEG_RIGHT - idx_s;
            s_ent = SINE_TAB[idx_s];
            c_ent = SINE_TAB[idx_c];
            nx[i].t     = t_w;
            nx[i].t_ok  = (t_w <= DEG_LAST);
            nx[i].pa_hi = PROD_W'(st[i-1].ay) * PROD_W'(c_ent[SINE_W-1 -: SINE_HI_W]);
            nx[i].pa_lo = PROD_W'(st[i-1].ay) * PROD_W'(c_ent[SINE_LO_W-1:0]);
            nx[i].pb_hi = PROD_W'(st[i-1].ax) * PROD_W'(s_ent[SINE_W-1 -: SINE_HI_W]);
            nx[i].pb_lo = PROD_W'(st[i-1].ax) * PROD_W'(s_ent[SINE_LO_W-1:0]);
          end

          // Search step, second half: keep the candidate degree if |y|*cos >= |x|*sin.
          if (IS_CMP) begin
            lhs = (CMP_W'(st[i-1].pa_hi) << SINE_LO_W) + CMP_W'(st[i-1].pa_lo);
            rhs = (CMP_W'(st[i-1].pb_hi) << SINE_LO_W) + CMP_W'(st[i-1].pb_lo);
            if (st[i-1].t_ok && (lhs >= rhs)) begin
              nx[i].d = st[i-1].t;
            end
          end

          // Squares of both magnitudes.
          if (i == ST_SQUARE) begin
            nx[i].sq_x = SUM_W'(st[i-1].ax) * SUM_W'(st[i-1].ax);
            nx[i].sq_y = SUM_W'(st[i-1].ay) * SUM_W'(st[i-1].ay);
          end

          // Sum of squares, and the square root starts empty.
          if (i == ST_SUM) begin
            nx[i].v    = st[i-1].sq_x + st[i-1].sq_y;
            nx[i].rem  = '0;
            nx[i].root = '0;
          end

          // Two digits of the restoring square root per stage.
          if (IS_ROOT) begin
            for (int k = 0; k < ROOT_PER_ST; k++) begin
              nx[i].rem = {nx[i].rem[REM_W-3:0], nx[i].v[SUM_W-1 -: 2]};
              nx[i].v   = nx[i].v << 2;
              trial     = REM_W'({nx[i].root, 2'b01});
              if (nx[i].rem >= trial) begin
                nx[i].rem  = nx[i].rem - trial;
                nx[i].root = {nx[i].root[MAG_W-2:0], 1'b1};
              end else begin
                nx[i].root = {nx[i].root[MAG_W-2:0], 1'b0};
              end
            end
          end

          // Fold into 0..180, snap near horizontal, pick the direction of travel.
          if (i == ST_ANGLE) begin
            if ((st[i-1].x_pos) == (!st[i-1].y_neg)) begin
              a_raw = (ANGLE_W+1)'(st[i-1].d);
            end else begin
              a_raw = (ANGLE_W+1)'(ANGLE_BACK) - (ANGLE_W+1)'(st[i-1].d);
            end
            snapped = (a_raw <= (ANGLE_W+1)'(snap)) ||
                      ((a_raw + (ANGLE_W+1)'(snap)) >= (ANGLE_W+1)'(ANGLE_BACK));
            if (st[i-1].x_zero) begin
              a_fin = st[i-1].y_zero ? (ANGLE_W+1)'(ANGLE_FWD) : (ANGLE_W+1)'(ANGLE_UP);
            end else if (snapped) begin
              a_fin = st[i-1].x_pos ? (ANGLE_W+1)'(ANGLE_FWD) : (ANGLE_W+1)'(ANGLE_BACK);
            end else begin
              a_fin = a_raw;
            end
            nx[i].angle = ANGLE_W'(a_fin);
            nx[i].neg   = st[i-1].y_neg && (a_fin > (ANGLE_W+1)'(snap)) &&
                          ((a_fin + (ANGLE_W+1)'(snap)) < (ANGLE_W+1)'(ANGLE_BACK));
            nx[i].mag   = (st[i-1].root > MAG_SAT) ? MAG_SAT : st[i-1].root;
          end

          // Apply the sign to the saturated magnitude.
          if (i == NST) begin
            nx[i].speed = st[i-1].neg ? SPEED_W'(MAG_W'(0) - st[i-1].mag) : st[i-1].mag;
          end
        end
      end
    end
  endgenerate

  // Port side of the pipeline.
  assign sample.ready     = adv[1];
  assign result.valid     = vld[NST];
  assign result.angle_deg = st[NST].angle;
  assign result.speed     = st[NST].speed;

  // The folded direction never leaves 0..180.
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.angle_deg <= ANGLE_BACK))
    else $error("angle_deg out of range");

  // Speed stays within full scale in either direction.
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.speed <= $signed({1'b0, MAG_SAT[MAG_W-2:0]})) &&
                      (result.speed >= -$signed({1'b0, MAG_SAT[MAG_W-2:0]}))))
    else $error("speed beyond full scale");

  // The search never settles on a degree past the last table boundary.
  assert property (@(posedge clk) disable iff (rst)
    vld[ST_SEARCH_END] |-> (st[ST_SEARCH_END].d <= DEG_LAST))
    else $error("search degree out of range");

  // A centred or vertical stick gives only forward or straight-up directions.
  assert property (@(posedge clk) disable iff (rst)
    (vld[ST_ANGLE] && st[ST_ANGLE].x_zero) |->
      ((st[ST_ANGLE].angle == ANGLE_FWD) || (st[ST_ANGLE].angle == ANGLE_UP)))
    else $error("vertical stick gave a side angle");

  // The angle stage keeps a transaction that it holds and cannot move on.
  assert property (@(posedge clk) disable iff (rst)
    (vld[ST_ANGLE] && !adv[ST_ANGLE]) |=> vld[ST_ANGLE])
    else $error("stalled transaction dropped");

endmodule
